### src/flconv_pkg.sv
package flconv_pkg;

  localparam int SAMPLE_BITS  = 16;
  localparam int MAX_TAPS_DEF = 64;
  localparam int OUT_BITS     = 38;
  localparam int PROD_BITS    = 2 * SAMPLE_BITS;
  localparam int TC_BITS      = 7;
  localparam int TAP_IDX_BITS = 6;
  localparam int APB_AW       = 3;
  localparam int APB_DW       = 32;

  typedef enum logic {
    REG_TAP_COUNT = 1'b0
  } reg_idx_t;

  typedef enum logic {
    ACT_COEF   = 1'b0,
    ACT_SAMPLE = 1'b1
  } action_t;

  typedef struct packed {
    action_t                        action;
    logic [TAP_IDX_BITS-1:0]        tap_index;
    logic signed [SAMPLE_BITS-1:0]  value;
    logic                           last_sample;
  } in_item_t;

  typedef struct packed {
    logic signed [OUT_BITS-1:0] out_sample;
    logic                       out_last;
  } out_item_t;

endpackage

### src/full_linear_convolution.sv
// Full linear convolution of a sample block with a stored impulse response,
// using one multiply-accumulate that steps one tap per cycle through a
// coefficient memory and a circular sample-history memory. A coefficient item
// is stored as it is taken. A sample item is pushed into the history and
// its output is formed tap by tap; with last_sample set, tap_count - 1 tail
// outputs follow, each from a pushed zero sample; the history is then cleared
// at once. The input is stalled while a sample or its tail is in progress.
// The output register lets a finished result wait while the next item is
// taken. Program tap_count (1 to MAX_TAPS) at address 0 only while idle.
module full_linear_convolution
  import flconv_pkg::*;
#(
  parameter int MAX_TAPS = MAX_TAPS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  in_item_t          req,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output out_item_t         rsp,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int IDX_W = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int TAP_W = $clog2(MAX_TAPS + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DRAIN
  } state_t;

  state_t state;

  logic [TC_BITS-1:0] tap_count;
  logic [TAP_W-1:0]   taps;

  logic signed [SAMPLE_BITS-1:0] coef_mem [MAX_TAPS];
  logic signed [SAMPLE_BITS-1:0] hist_mem [MAX_TAPS];
  logic [MAX_TAPS-1:0]           hvalid;

  logic [IDX_W-1:0] wp;
  logic [IDX_W-1:0] wp_next;
  logic [IDX_W-1:0] rp;
  logic [IDX_W-1:0] j;
  logic [TAP_W-1:0] rem;
  logic             last_q;

  logic signed [SAMPLE_BITS-1:0] coef_rd;
  logic signed [SAMPLE_BITS-1:0] hist_rd;
  logic                          hv_rd;
  logic                          rd_live;
  logic signed [PROD_BITS-1:0]   prod;
  logic                          prod_live;
  logic signed [OUT_BITS-1:0]    acc;

  logic                          req_take;
  logic                          coef_we;
  logic                          push_en;
  logic signed [SAMPLE_BITS-1:0] push_data;
  logic                          emit;
  logic                          cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready
                  && (reg_idx_t'(paddr[APB_AW-1]) == REG_TAP_COUNT);

  always_comb begin
    prdata = '0;
    if (reg_idx_t'(paddr[APB_AW-1]) == REG_TAP_COUNT) begin
      prdata[TC_BITS-1:0] = tap_count;
    end
  end

  always_comb begin
    if (tap_count == '0) begin
      taps = TAP_W'(1);
    end else if (tap_count > TC_BITS'(MAX_TAPS)) begin
      taps = TAP_W'(MAX_TAPS);
    end else begin
      taps = TAP_W'(tap_count);
    end
  end

  assign req_stall = (state != S_IDLE);
  assign req_take  = req_valid && !req_stall;
  assign coef_we   = req_take && (req.action == ACT_COEF)
                     && ({1'b0, req.tap_index} < (TAP_IDX_BITS + 1)'(MAX_TAPS));
  assign emit      = (state == S_DRAIN) && !rd_live && !prod_live
                     && (!rsp_valid || !rsp_stall);
  assign wp_next   = (wp == IDX_W'(MAX_TAPS - 1)) ? '0 : wp + 1'b1;

  always_comb begin
    push_en   = 1'b0;
    push_data = '0;
    if (req_take && (req.action == ACT_SAMPLE)) begin
      push_en   = 1'b1;
      push_data = req.value;
    end else if (emit && (rem != '0)) begin
      push_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (coef_we) begin
      coef_mem[req.tap_index[IDX_W-1:0]] <= req.value;
    end
    coef_rd <= coef_mem[j];
  end

  always_ff @(posedge clk) begin
    if (push_en) begin
      hist_mem[wp_next] <= push_data;
    end
    hist_rd <= hist_mem[rp];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      tap_count <= TC_BITS'(1);
      hvalid    <= '0;
      wp        <= '0;
      rd_live   <= 1'b0;
      prod_live <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        tap_count <= pwdata[TC_BITS-1:0];
      end

      if (rsp_valid && !rsp_stall && !emit) begin
        rsp_valid <= 1'b0;
      end

      rd_live   <= (state == S_RUN);
      hv_rd     <= hvalid[rp];
      prod_live <= rd_live;
      if (rd_live) begin
        prod <= coef_rd * (hv_rd ? hist_rd : SAMPLE_BITS'(0));
      end
      if (prod_live) begin
        acc <= acc + OUT_BITS'(prod);
      end

      if (push_en) begin
        wp              <= wp_next;
        hvalid[wp_next] <= 1'b1;
        rp              <= wp_next;
        j               <= '0;
        acc             <= '0;
        state           <= S_RUN;
      end

      unique case (state)
        S_IDLE: begin
          if (req_take && (req.action == ACT_SAMPLE)) begin
            last_q <= req.last_sample;
            rem    <= req.last_sample ? taps - 1'b1 : '0;
          end
        end
        S_RUN: begin
          j  <= j + 1'b1;
          rp <= (rp == '0) ? IDX_W'(MAX_TAPS - 1) : rp - 1'b1;
          if (TAP_W'(j) == taps - 1'b1) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (emit) begin
            rsp_valid      <= 1'b1;
            rsp.out_sample <= acc;
            rsp.out_last   <= last_q && (rem == '0);
            if (rem != '0) begin
              rem <= rem - 1'b1;
            end else begin
              state <= S_IDLE;
              if (last_q) begin
                hvalid <= '0;
              end
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
